// ===== rtl/sclp_pkg.sv =====
`timescale 1ns / 1ps

package sclp_pkg;

    // Line buffer capacity in characters; the line ends at capacity minus one.
    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);

    // Number of keywords and the longest keyword slot.
    localparam int KW_COUNT = 5;
    localparam int KW_SLOTS = 8;

    // Character codes with a special meaning.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Length of the time string "set hh:mm:ss A".
    localparam int TIME_LINE_LEN = 14;

    // Result codes.
    typedef enum logic [2:0] {
        KIND_UNKNOWN   = 3'd0,
        KIND_TRACE_ON  = 3'd1,
        KIND_TRACE_OFF = 3'd2,
        KIND_SET       = 3'd3,
        KIND_BAD_TIME  = 3'd4,
        KIND_GET       = 3'd5,
        KIND_RESET     = 3'd6
    } kind_t;

    // Keyword table, tested in index order: TRON, TROFF, SET, GET, RESET.
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
        '{"T", "R", "O", "N", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "R", "O", "F", "F",   8'h00, 8'h00, 8'h00},
        '{"S", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"R", "E", "S", "E", "T",   8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd5, 3'd3, 3'd3, 3'd5};
    localparam kind_t KW_KIND [KW_COUNT] =
        '{KIND_TRACE_ON, KIND_TRACE_OFF, KIND_SET, KIND_GET, KIND_RESET};

    // Running match state of the current line.
    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [KW_COUNT-1:0] alive;
        logic [KW_COUNT-1:0] hit;
        logic                fmt_ok;
        logic [5:0][3:0]     digits;
        logic                pm;
    } line_state_t;

    // State of an empty line.
    function automatic line_state_t line_clear();
        line_state_t s;
        s.len    = '0;
        s.alive  = '1;
        s.hit    = '0;
        s.fmt_ok = 1'b1;
        s.digits = '0;
        s.pm     = 1'b0;
        return s;
    endfunction

endpackage

// ===== rtl/serial_command_line_parser_unit.sv =====
`timescale 1ns / 1ps

// Timing: a character is registered on transfer, and its result is registered when the
// input stage advances, which waits while a held result has not yet been taken.
// Throughput: one character per cycle while the output is not stalled; the per-character
// update of the line state is the only loop.
// Reset: rst_n clears the line state to an empty line and empties both stages.
module serial_command_line_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] result_kind,
    output logic [6:0] seconds_bcd,
    output logic [6:0] minutes_bcd,
    output logic [6:0] hours_word
);

    localparam int LW = sclp_pkg::LEN_W;

    // Input stage.
    logic       in_valid_reg;
    logic [7:0] char_reg;

    // Line state.
    sclp_pkg::line_state_t state_reg;
    sclp_pkg::line_state_t state_next;
    sclp_pkg::line_state_t taken;
    sclp_pkg::line_state_t fin_src;

    // Output stage.
    logic            out_valid_reg;
    sclp_pkg::kind_t kind_reg;
    logic [6:0]      seconds_reg;
    logic [6:0]      minutes_reg;
    logic [6:0]      hours_reg;

    logic                          advance;
    logic                          is_term;
    logic                          is_esc;
    logic                          is_last;
    logic                          emit;
    logic [7:0]                    up_char;
    logic                          pos_ok;
    logic [sclp_pkg::KW_COUNT-1:0] hits;
    sclp_pkg::kind_t               kind_next;
    logic                          time_ok;
    logic [6:0]                    seconds_next;
    logic [6:0]                    minutes_next;
    logic [6:0]                    hours_next;

    // Handshake: the input stage moves on whenever the output stage can take a transfer.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;

    assign result_kind = kind_reg;
    assign seconds_bcd = seconds_reg;
    assign minutes_bcd = minutes_reg;
    assign hours_word  = hours_reg;

    // Character classes.
    assign is_term = (char_reg == sclp_pkg::CH_CR) || (char_reg == sclp_pkg::CH_LF)
                  || (char_reg == sclp_pkg::CH_NUL);
    assign is_esc  = (char_reg == sclp_pkg::CH_ESC);
    assign up_char = (char_reg >= sclp_pkg::CH_LO_A && char_reg <= sclp_pkg::CH_LO_Z)
                   ? char_reg - sclp_pkg::CASE_GAP : char_reg;

    // Take one character into the running match state.
    always_comb
    begin
        taken  = state_reg;
        pos_ok = 1'b1;
        for (int k = 0; k < sclp_pkg::KW_COUNT; k++)
        begin
            if (state_reg.len < LW'(sclp_pkg::KW_LEN[k]))
            begin
                if (up_char != sclp_pkg::KW_TEXT[k][state_reg.len[2:0]])
                begin
                    taken.alive[k] = 1'b0;
                end
            end
            else if (state_reg.len == LW'(sclp_pkg::KW_LEN[k]))
            begin
                if (state_reg.alive[k] && char_reg == sclp_pkg::CH_SPACE)
                begin
                    taken.hit[k] = 1'b1;
                end
                taken.alive[k] = 1'b0;
            end
        end
        unique case (state_reg.len)
            LW'(3), LW'(12):
            begin
                pos_ok = (char_reg == sclp_pkg::CH_SPACE);
            end
            LW'(6), LW'(9):
            begin
                pos_ok = (char_reg == sclp_pkg::CH_COLON);
            end
            LW'(4):
            begin
                pos_ok = char_reg >= sclp_pkg::CH_ZERO && char_reg <= sclp_pkg::CH_ONE;
                taken.digits[0] = char_reg[3:0];
            end
            LW'(5):
            begin
                pos_ok = char_reg >= sclp_pkg::CH_ZERO && char_reg <= sclp_pkg::CH_NINE;
                taken.digits[1] = char_reg[3:0];
            end
            LW'(7):
            begin
                pos_ok = char_reg >= sclp_pkg::CH_ZERO && char_reg <= sclp_pkg::CH_FIVE;
                taken.digits[2] = char_reg[3:0];
            end
            LW'(8):
            begin
                pos_ok = char_reg >= sclp_pkg::CH_ZERO && char_reg <= sclp_pkg::CH_NINE;
                taken.digits[3] = char_reg[3:0];
            end
            LW'(10):
            begin
                pos_ok = char_reg >= sclp_pkg::CH_ZERO && char_reg <= sclp_pkg::CH_FIVE;
                taken.digits[4] = char_reg[3:0];
            end
            LW'(11):
            begin
                pos_ok = char_reg >= sclp_pkg::CH_ZERO && char_reg <= sclp_pkg::CH_NINE;
                taken.digits[5] = char_reg[3:0];
            end
            LW'(13):
            begin
                pos_ok   = (char_reg == sclp_pkg::CH_UP_A) || (char_reg == sclp_pkg::CH_UP_P);
                taken.pm = (char_reg == sclp_pkg::CH_UP_P);
            end
            default:
            begin
                pos_ok = 1'b1;
            end
        endcase
        taken.fmt_ok = state_reg.fmt_ok & pos_ok;
        taken.len    = state_reg.len + LW'(1);
    end

    // A line yields a result on a terminator if it is not empty, or when the taken character fills it to the limit.
    assign is_last = !is_term && !is_esc && (taken.len == LW'(sclp_pkg::LINE_CAPACITY - 1));
    assign emit    = (is_term && state_reg.len != '0) || is_last;
    assign fin_src = is_term ? state_reg : taken;

    // Classify the finished line and pack the time fields.
    always_comb
    begin
        hits      = fin_src.hit;
        kind_next = sclp_pkg::KIND_UNKNOWN;
        for (int k = 0; k < sclp_pkg::KW_COUNT; k++)
        begin
            if (fin_src.alive[k] && fin_src.len == LW'(sclp_pkg::KW_LEN[k]))
            begin
                hits[k] = 1'b1;
            end
        end
        for (int k = sclp_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            if (hits[k])
            begin
                kind_next = sclp_pkg::KW_KIND[k];
            end
        end
        time_ok = fin_src.fmt_ok && fin_src.len == LW'(sclp_pkg::TIME_LINE_LEN)
               && !(fin_src.digits[0] == 4'd0 && fin_src.digits[1] == 4'd0)
               && !(fin_src.digits[0] == 4'd1 && fin_src.digits[1] > 4'd2);
        seconds_next = '0;
        minutes_next = '0;
        hours_next   = '0;
        if (kind_next == sclp_pkg::KIND_SET)
        begin
            if (time_ok)
            begin
                seconds_next = {fin_src.digits[4][2:0], fin_src.digits[5]};
                minutes_next = {fin_src.digits[2][2:0], fin_src.digits[3]};
                hours_next   = {fin_src.digits[0][2:0], fin_src.digits[1]}
                             | {1'b1, fin_src.pm, 5'b0};
            end
            else
            begin
                kind_next = sclp_pkg::KIND_BAD_TIME;
            end
        end
    end

    // Next line state.
    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            if (is_term || is_esc || is_last)
            begin
                state_next = sclp_pkg::line_clear();
            end
            else
            begin
                state_next = taken;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= sclp_pkg::line_clear();
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
        end
        if (advance && emit)
        begin
            kind_reg    <= kind_next;
            seconds_reg <= seconds_next;
            minutes_reg <= minutes_next;
            hours_reg   <= hours_next;
        end
    end

`ifndef ASSERT_OFF
    // A result always starts a fresh, empty line.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> state_reg.len == '0 && state_reg.alive == '1)
        else $error("line state not cleared after a result");

    // An escape clears the line and yields no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_esc |=> state_reg.len == '0 && !out_valid_reg)
        else $error("escape did not clear the line");

    // The line never reaches the capacity limit in storage.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.len < LW'(sclp_pkg::LINE_CAPACITY - 1))
        else $error("line length overran the limit");

    // Time fields are zero unless a valid time was set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != sclp_pkg::KIND_SET
        |-> seconds_reg == '0 && minutes_reg == '0 && hours_reg == '0)
        else $error("time fields set on a non-time result");

    // A valid time always carries the 12-hour mode flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == sclp_pkg::KIND_SET |-> hours_reg[6])
        else $error("12-hour flag missing");
`endif

endmodule
